/* rtl/fnfs_pkg.sv */
`default_nettype none
package fnfs_pkg;

   // character codes the splitter reacts to
   localparam logic [7:0] CHAR_NUL       = 8'h00;
   localparam logic [7:0] CHAR_SLASH     = 8'h2F;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_DOT       = 8'h2E;
   localparam logic [7:0] CHAR_MINUS     = 8'h2D;
   localparam logic [7:0] CHAR_HASH      = 8'h23;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_NINE      = 8'h39;

   // position marker for no separator or dot seen yet
   localparam logic [16:0] POS_NONE = 17'h1FFFF;

   localparam logic [15:0] MAX_LENGTH_RESET = 16'hFFFF;

   // sizes captured at the end of a name, before the base is worked out
   typedef struct packed {
      logic [15:0] name_length;
      logic [15:0] path_size;
      logic [15:0] extension_size;
      logic [16:0] number_size;
   } sizes_type;

endpackage
`default_nettype wire

/* rtl/file_name_field_splitter.sv */
`default_nettype none
// channel   direction  handshake              payload
// req       in         req_valid / req_stall  req_char_code, req_last_char
// rsp       out        rsp_valid / rsp_stall  name, path, base, number, extension sizes
// csr       in         csr_write_enable       csr_write_data (max_length)
//
// One character is taken every cycle while req_stall is low; the running scan state
// is updated in the same cycle it is accepted. A name's sizes are captured into the mid
// stage on its last character; the base size is then formed and registered into rsp.
// Synchronous reset clears the scan and both result stage valids; max_length goes to 65535.
// A stalled rsp only holds back a last character, and only once both result stages are full.
module file_name_field_splitter
   import fnfs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_char_code,
   input  wire logic        req_last_char,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_name_length,
   output logic [15:0]      rsp_path_size,
   output logic [15:0]      rsp_base_size,
   output logic [15:0]      rsp_number_size,
   output logic [15:0]      rsp_extension_size,
   input  wire logic        csr_write_enable,
   input  wire logic [15:0] csr_write_data
);

   logic [15:0] max_length_ff;

   // scan state
   logic [15:0] chars_seen_ff,  chars_seen_in;
   logic        ended_ff,       ended_in;
   logic [16:0] sep_pos_ff,     sep_pos_in;
   logic [16:0] dot_pos_ff,     dot_pos_in;
   logic        dot_valid_ff,   dot_valid_in;
   logic        prev_minus_ff,  prev_minus_in;
   logic [15:0] digit_run_ff,   digit_run_in;
   logic [15:0] hash_run_ff,    hash_run_in;
   logic        minus_run_ff,   minus_run_in;
   logic [15:0] dot_run_ff,     dot_run_in;
   logic        minus_dot_ff,   minus_dot_in;

   // result stages
   logic        mid_valid_ff;
   sizes_type   mid_ff, mid_in;
   logic        rsp_valid_ff;
   logic [15:0] len_ff, path_ff, base_ff, num_ff, ext_ff;

   logic        req_accept;
   logic        take;
   logic        is_sep, is_dot, is_digit, is_hash, is_minus;
   logic        mid_load;
   logic        rsp_load;
   logic [17:0] part_sum;
   logic [15:0] base_in;

   // flow control between the two result stages and the port
   assign rsp_load   = mid_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = req_last_char && mid_valid_ff && !rsp_load;
   assign req_accept = req_valid && !req_stall;
   assign take       = req_accept && !ended_ff && (chars_seen_ff < max_length_ff)
                       && (req_char_code != CHAR_NUL);
   assign mid_load   = req_accept && req_last_char;

   // character classes
   always_comb begin
      is_sep   = 1'b0;
      is_dot   = 1'b0;
      is_digit = 1'b0;
      is_hash  = 1'b0;
      is_minus = 1'b0;
      case (req_char_code) inside
         CHAR_SLASH, CHAR_BACKSLASH: is_sep   = 1'b1;
         CHAR_DOT:                   is_dot   = 1'b1;
         [CHAR_ZERO:CHAR_NINE]:      is_digit = 1'b1;
         CHAR_HASH:                  is_hash  = 1'b1;
         CHAR_MINUS:                 is_minus = 1'b1;
         default:                    ;
      endcase
   end

   // next scan state for one character
   always_comb begin
      chars_seen_in = chars_seen_ff;
      ended_in      = ended_ff;
      sep_pos_in    = sep_pos_ff;
      dot_pos_in    = dot_pos_ff;
      dot_valid_in  = dot_valid_ff;
      prev_minus_in = prev_minus_ff;
      digit_run_in  = digit_run_ff;
      hash_run_in   = hash_run_ff;
      minus_run_in  = minus_run_ff;
      dot_run_in    = dot_run_ff;
      minus_dot_in  = minus_dot_ff;
      if (req_accept && !ended_ff && (chars_seen_ff < max_length_ff)
          && (req_char_code == CHAR_NUL)) begin
         ended_in = 1'b1;
      end
      if (take) begin
         chars_seen_in = chars_seen_ff + 16'd1;
         prev_minus_in = is_minus;
         digit_run_in  = 16'd0;
         hash_run_in   = 16'd0;
         if (is_sep) begin
            sep_pos_in   = {1'b0, chars_seen_ff};
            dot_valid_in = 1'b0;
         end else if (is_dot) begin
            dot_pos_in = {1'b0, chars_seen_ff};
            if (chars_seen_ff == 16'd0) begin
               dot_valid_in = 1'b0;
            end else if (sep_pos_ff == POS_NONE) begin
               dot_valid_in = 1'b1;
            end else begin
               dot_valid_in = {1'b0, chars_seen_ff} > (sep_pos_ff + 17'd1);
            end
            if (digit_run_ff != 16'd0) begin
               dot_run_in   = digit_run_ff;
               minus_dot_in = minus_run_ff;
            end else begin
               dot_run_in   = hash_run_ff;
               minus_dot_in = 1'b0;
            end
         end else if (is_digit) begin
            if (digit_run_ff == 16'd0) begin
               minus_run_in = prev_minus_ff;
            end
            digit_run_in = digit_run_ff + 16'd1;
         end else if (is_hash) begin
            hash_run_in = hash_run_ff + 16'd1;
         end
      end
   end

   // sizes at the end of a name
   always_comb begin
      mid_in = '0;
      if (chars_seen_in != 16'd0) begin
         mid_in.name_length = chars_seen_in;
         if (sep_pos_in != POS_NONE) begin
            mid_in.path_size = sep_pos_in[15:0] + 16'd1;
         end
         if (dot_valid_in && (dot_pos_in != POS_NONE)
             && (dot_pos_in < {1'b0, chars_seen_in})) begin
            mid_in.extension_size = chars_seen_in - dot_pos_in[15:0];
            mid_in.number_size    = {1'b0, dot_run_in} + {16'd0, minus_dot_in};
         end else if (digit_run_in != 16'd0) begin
            mid_in.number_size = {1'b0, digit_run_in} + {16'd0, minus_run_in};
         end else begin
            mid_in.number_size = {1'b0, hash_run_in};
         end
      end
   end

   // base is what the other fields leave over
   always_comb begin
      part_sum = {2'b00, mid_ff.path_size} + {2'b00, mid_ff.extension_size}
                 + {1'b0, mid_ff.number_size};
      base_in  = 16'd0;
      if ({2'b00, mid_ff.name_length} >= part_sum) begin
         base_in = mid_ff.name_length - part_sum[15:0];
      end
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= MAX_LENGTH_RESET;
      end else if (csr_write_enable) begin
         max_length_ff <= csr_write_data;
      end
   end

   // scan state, cleared after each name's last character
   always_ff @(posedge clock) begin
      if (reset || mid_load) begin
         chars_seen_ff <= 16'd0;
         ended_ff      <= 1'b0;
         sep_pos_ff    <= POS_NONE;
         dot_pos_ff    <= POS_NONE;
         dot_valid_ff  <= 1'b0;
         prev_minus_ff <= 1'b0;
         digit_run_ff  <= 16'd0;
         hash_run_ff   <= 16'd0;
         minus_run_ff  <= 1'b0;
         dot_run_ff    <= 16'd0;
         minus_dot_ff  <= 1'b0;
      end else begin
         chars_seen_ff <= chars_seen_in;
         ended_ff      <= ended_in;
         sep_pos_ff    <= sep_pos_in;
         dot_pos_ff    <= dot_pos_in;
         dot_valid_ff  <= dot_valid_in;
         prev_minus_ff <= prev_minus_in;
         digit_run_ff  <= digit_run_in;
         hash_run_ff   <= hash_run_in;
         minus_run_ff  <= minus_run_in;
         dot_run_ff    <= dot_run_in;
         minus_dot_ff  <= minus_dot_in;
      end
   end

   // result stage valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (mid_load) begin
            mid_valid_ff <= 1'b1;
         end else if (rsp_load) begin
            mid_valid_ff <= 1'b0;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result stage payload
   always_ff @(posedge clock) begin
      if (mid_load) begin
         mid_ff <= mid_in;
      end
      if (rsp_load) begin
         len_ff  <= mid_ff.name_length;
         path_ff <= mid_ff.path_size;
         base_ff <= base_in;
         num_ff  <= mid_ff.number_size[15:0];
         ext_ff  <= mid_ff.extension_size;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_name_length    = len_ff;
   assign rsp_path_size      = path_ff;
   assign rsp_base_size      = base_ff;
   assign rsp_number_size    = num_ff;
   assign rsp_extension_size = ext_ff;

endmodule
`default_nettype wire
